/* hdl/ckst_pkg.sv */
// ----------------------------------------------------------------------------
// ckst_pkg: shared types and constants of the shutdown timer
// Action codes, chord masks, period limits and the command word that travels
// from the front part to the back part.
// ----------------------------------------------------------------------------
package ckst_pkg;

  // Input action codes
  localparam logic [1:0] ActKey   = 2'd0;
  localparam logic [1:0] ActTick  = 2'd1;
  localparam logic [1:0] ActStart = 2'd2;

  // Period limits (seconds)
  localparam logic [11:0] DefaultPeriod = 12'd300;
  localparam logic [15:0] SavedMax      = 16'd3600;
  localparam logic [15:0] SavedMin      = 16'd5;
  localparam logic [15:0] SavedReset    = 16'd300;
  localparam logic [11:0] PeriodStep    = 12'd5;
  localparam logic [11:0] UpLimit       = 12'd3595;
  localparam logic [11:0] DownLimit     = 12'd9;
  localparam logic [15:0] RemainStep    = 16'd5;
  localparam logic [15:0] RemainMax     = 16'hFFFF;
  localparam logic [15:0] RemainUpTop   = 16'd65530;
  localparam logic [15:0] RemainReset   = 16'd300;

  // Chord codes: bit2 power, bit1 up, bit0 down
  localparam logic [2:0] ChordNone  = 3'b000;
  localparam logic [2:0] ChordDown  = 3'b001;
  localparam logic [2:0] ChordUp    = 3'b010;
  localparam logic [2:0] ChordBoth  = 3'b011;
  localparam logic [2:0] ChordPower = 3'b100;

  // Command queue depth
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OP_KEY,
    OP_TICK,
    OP_START,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  code;
    logic [11:0] load_period;
  } cmd_t;

endpackage

/* hdl/ckst_if.sv */
// ----------------------------------------------------------------------------
// ckst_if: handshake channels of the shutdown timer
// Input word, result word and configuration write channel.
// ----------------------------------------------------------------------------
interface ckst_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       power_key;
  logic       up_key;
  logic       down_key;

  modport source (output valid, action, power_key, up_key, down_key, input ready);
  modport sink   (input valid, action, power_key, up_key, down_key, output ready);
endinterface

interface ckst_out_if;
  logic        valid;
  logic        ready;
  logic        relay_on;
  logic [11:0] period_seconds;
  logic [15:0] remaining_seconds;
  logic [2:0]  chord_acted;
  logic        period_changed;

  modport source (output valid, relay_on, period_seconds, remaining_seconds, chord_acted,
                  period_changed, input ready);
  modport sink   (input valid, relay_on, period_seconds, remaining_seconds, chord_acted,
                  period_changed, output ready);
endinterface

interface ckst_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] saved_seconds;

  modport source (output valid, saved_seconds, input ready);
  modport sink   (input valid, saved_seconds, output ready);
endinterface

/* hdl/chord_keyed_shutdown_timer.sv */
// ----------------------------------------------------------------------------
// chord_keyed_shutdown_timer: self-shutdown relay timer with button chords
// Start loads the period from the saved value, key samples drive a chord
// detector that adjusts the period, one-second ticks count down to relay off.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    action, power_key, up_key, down_key
//   out_o    out  valid/ready    relay_on, period_seconds, remaining_seconds,
//                                chord_acted, period_changed
//   cfg_i    in   valid/ready    saved_seconds (always ready)
//
// One word per cycle sustained while out_o.ready stays high. Each word passes
// through the two-entry command queue, then the executor's result register.
// Reset clears the queue and the result register and loads the reset state:
// period and remaining 300, relay on, chord detector empty, flag clear.
// A stalled result holds in its register; the queue keeps taking words until
// it holds two, then in_i.ready drops.
// ----------------------------------------------------------------------------
module chord_keyed_shutdown_timer (
  input  logic      clk_i,
  input  logic      rst_ni,
  ckst_in_if.sink   in_i,
  ckst_cfg_if.sink  cfg_i,
  ckst_out_if.source out_o
);
  import ckst_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // Front: classify words, check the saved period, queue commands
  ckst_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  // Back: run the chord detector, timer and relay, register results
  ckst_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // A consumed power chord always leaves the relay off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.chord_acted == ChordPower) |-> !out_o.relay_on)
    else $error("power chord did not switch the relay off");

  // Any period-adjusting chord sets the sticky flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.chord_acted == ChordUp || out_o.chord_acted == ChordDown ||
                     out_o.chord_acted == ChordBoth)) |-> out_o.period_changed)
    else $error("period chord did not set the changed flag");

  // Period never leaves its legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.period_seconds <= SavedMax[11:0]))
    else $error("period out of range");

  // A result held under stall keeps its relay state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(out_o.relay_on))
    else $error("stalled result changed");

endmodule

/* hdl/ckst_front.sv */
// ----------------------------------------------------------------------------
// ckst_front: accept and classify input words
// Decodes the action, packs the key chord, range-checks the saved period and
// queues the command for the back part.
// ----------------------------------------------------------------------------
module ckst_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ckst_in_if.sink              in_i,
  ckst_cfg_if.sink             cfg_i,
  output logic                 q_valid_o,
  output ckst_pkg::cmd_t       q_cmd_o,
  input  logic                 q_pop_i
);
  import ckst_pkg::*;

  logic [15:0]      saved_q;
  cmd_t             cmd;
  cmd_t             queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_q <= SavedReset;
    end else if (cfg_i.valid) begin
      saved_q <= cfg_i.saved_seconds;
    end
  end

  // Classify the incoming word
  always_comb begin
    cmd.code = {in_i.power_key, in_i.up_key, in_i.down_key};
    if (saved_q > SavedMax || saved_q < SavedMin) begin
      cmd.load_period = DefaultPeriod;
    end else begin
      cmd.load_period = saved_q[11:0];
    end
    unique case (in_i.action)
      ActKey:   cmd.op = OP_KEY;
      ActTick:  cmd.op = OP_TICK;
      ActStart: cmd.op = OP_START;
      default:  cmd.op = OP_NOP;
    endcase
  end

  assign in_i.ready = (cnt_q != QCntW'(QDepth));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o   = queue_q[rd_ptr_q];

endmodule

/* hdl/ckst_back.sv */
// ----------------------------------------------------------------------------
// ckst_back: execute queued commands
// Holds the chord detector, period, remaining time and relay state, and
// registers one result word per command.
// ----------------------------------------------------------------------------
module ckst_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  ckst_pkg::cmd_t       q_cmd_i,
  output logic                 q_pop_o,
  ckst_out_if.source           out_o
);
  import ckst_pkg::*;

  logic [2:0]  held_q, held_d;
  logic [11:0] period_q, period_d;
  logic [15:0] remain_q, remain_d;
  logic        relay_q, relay_d;
  logic        changed_q, changed_d;
  logic [2:0]  acted_d, acted_q;
  logic        out_valid_q;

  // The latched chord is always consumed in the same word, so it never
  // survives between words and needs no register.
  always_comb begin
    held_d    = held_q;
    period_d  = period_q;
    remain_d  = remain_q;
    relay_d   = relay_q;
    changed_d = changed_q;
    acted_d   = ChordNone;
    unique case (q_cmd_i.op)
      OP_START: begin
        period_d  = q_cmd_i.load_period;
        remain_d  = {4'd0, q_cmd_i.load_period};
        relay_d   = 1'b1;
        held_d    = ChordNone;
        changed_d = 1'b0;
      end
      OP_KEY: begin
        if (relay_q) begin
          if (q_cmd_i.code >= held_q) begin
            held_d = q_cmd_i.code;
          end else begin
            acted_d = held_q;
            if (q_cmd_i.code == ChordNone) begin
              held_d = ChordNone;
            end
          end
          unique case (acted_d)
            ChordBoth: begin
              period_d  = DefaultPeriod;
              remain_d  = RemainReset;
              changed_d = 1'b1;
            end
            ChordDown: begin
              if (period_q > DownLimit) begin
                period_d = period_q - PeriodStep;
              end
              remain_d  = (remain_q > RemainStep) ? remain_q - RemainStep : '0;
              changed_d = 1'b1;
            end
            ChordUp: begin
              if (period_q < UpLimit) begin
                period_d = period_q + PeriodStep;
              end
              remain_d  = (remain_q > RemainUpTop) ? RemainMax : remain_q + RemainStep;
              changed_d = 1'b1;
            end
            ChordPower: begin
              relay_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      OP_TICK: begin
        if (relay_q) begin
          if (remain_q <= 16'd1) begin
            remain_d = '0;
            relay_d  = 1'b0;
          end else begin
            remain_d = remain_q - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign q_pop_o = q_valid_i && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= ChordNone;
      period_q    <= DefaultPeriod;
      remain_q    <= RemainReset;
      relay_q     <= 1'b1;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        held_q      <= held_d;
        period_q    <= period_d;
        remain_q    <= remain_d;
        relay_q     <= relay_d;
        changed_q   <= changed_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      acted_q <= acted_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.relay_on          = relay_q;
  assign out_o.period_seconds    = period_q;
  assign out_o.remaining_seconds = remain_q;
  assign out_o.chord_acted       = acted_q;
  assign out_o.period_changed    = changed_q;

endmodule

/* tb/tb_chord_keyed_shutdown_timer.sv */
// ----------------------------------------------------------------------------
// tb_chord_keyed_shutdown_timer: self-checking bench for the shutdown timer
// Drives words into the input channel from a queue, predicts each result in
// step with the accepted words and compares every result word field by field.
// Covers key chords, ticks, starts, the unused action and saved-period edges.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_chord_keyed_shutdown_timer;
  import ckst_pkg::*;

  // Action code that the block must ignore
  localparam logic [1:0] ActUnused = 2'd3;

  // Chords with no effect besides being reported
  localparam logic [2:0] ChordPowerDown = ChordPower | ChordDown;
  localparam logic [2:0] ChordPowerUp   = ChordPower | ChordUp;
  localparam logic [2:0] ChordAll       = ChordPower | ChordBoth;

  localparam int IdleLimit     = 5000;   // cycles with no handshake at all
  localparam int HoldOffCycles = 300;    // long receiver hold-off
  localparam int DrainCycles   = 4;      // command queue and result register plus margin
  localparam int RandomWords   = 400;

  // One input word: action plus keys packed as power, up, down
  typedef struct packed {
    logic [1:0] action;
    logic [2:0] keys;
  } key_word_t;

  // One result word
  typedef struct packed {
    logic        relay_on;
    logic [11:0] period;
    logic [15:0] remaining;
    logic [2:0]  acted;
    logic        changed;
  } timer_word_t;

  logic clk_i;
  logic rst_ni;

  ckst_in_if  in_if ();
  ckst_out_if out_if ();
  ckst_cfg_if cfg_if ();

  chord_keyed_shutdown_timer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Words waiting to be driven, and results waiting to come out
  key_word_t   pending_words[$];
  timer_word_t expected_words[$];

  // Predicted timer state, updated once per accepted word
  logic [15:0] saved_cfg;
  logic [2:0]  held_chord;
  logic [2:0]  latched_chord;
  logic [11:0] period_now;
  logic [15:0] remaining_now;
  logic        relay_now;
  logic        changed_now;

  // Run statistics
  int words_taken;
  int live_words;
  int results_seen;
  int cfg_writes;
  int chords_acted;
  int shutdowns;
  int peak_remaining;
  int errors;

  // Idling control, owned by the stimulus process
  logic steady;
  int   hold_req;

  // Driver, receiver and watchdog bookkeeping
  logic      in_took;
  int        in_gap;
  int        out_stall;
  int        hold_ack;
  int        hold_left;
  int        idle_cycles;
  key_word_t next_word;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor: advance the timer by one accepted word, return its result
  // --------------------------------------------------------------------------
  function automatic timer_word_t advance_timer(key_word_t w);
    timer_word_t res;
    logic [2:0]  acted;
    logic [15:0] load;
    acted = ChordNone;
    if (w.action == ActStart) begin
      // Fall back to the default period when the saved value is out of range
      load = saved_cfg;
      if (load > SavedMax || load < SavedMin) load = SavedReset;
      period_now    = load[11:0];
      remaining_now = load;
      relay_now     = 1'b1;
      held_chord    = ChordNone;
      latched_chord = ChordNone;
      changed_now   = 1'b0;
      live_words++;
    end else if (w.action == ActKey && relay_now) begin
      live_words++;
      // Keep the chord with the highest code; latch it once keys start to come up
      if (w.keys >= held_chord) begin
        held_chord = w.keys;
      end else begin
        if (latched_chord == ChordNone) latched_chord = held_chord;
        if (w.keys == ChordNone) held_chord = ChordNone;
      end
      acted         = latched_chord;
      latched_chord = ChordNone;
      case (acted)
        ChordBoth: begin
          period_now    = DefaultPeriod;
          remaining_now = RemainReset;
          changed_now   = 1'b1;
        end
        ChordDown: begin
          if (period_now > DownLimit) period_now = period_now - PeriodStep;
          remaining_now = (remaining_now > RemainStep) ? remaining_now - RemainStep : '0;
          changed_now   = 1'b1;
        end
        ChordUp: begin
          if (period_now < UpLimit) period_now = period_now + PeriodStep;
          remaining_now = (remaining_now > RemainUpTop) ? RemainMax
                                                        : remaining_now + RemainStep;
          changed_now   = 1'b1;
        end
        ChordPower: begin
          relay_now = 1'b0;
          shutdowns++;
        end
        default: begin
        end
      endcase
      if (acted != ChordNone) chords_acted++;
    end else if (w.action == ActTick && relay_now) begin
      live_words++;
      // Count down; a remaining of one or zero drops the relay
      if (remaining_now <= 16'd1) begin
        remaining_now = '0;
        relay_now     = 1'b0;
        shutdowns++;
      end else begin
        remaining_now = remaining_now - 16'd1;
      end
    end
    if (remaining_now > peak_remaining) peak_remaining = remaining_now;
    res.relay_on  = relay_now;
    res.period    = period_now;
    res.remaining = remaining_now;
    res.acted     = acted;
    res.changed   = changed_now;
    return res;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: take a fresh word once the previous one was accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_took <= in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready) begin
      next_word.action = in_if.action;
      next_word.keys   = {in_if.power_key, in_if.up_key, in_if.down_key};
      expected_words.push_back(advance_timer(next_word));
      words_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        in_if.valid     <= 1'b1;
        in_if.action    <= next_word.action;
        in_if.power_key <= next_word.keys[2];
        in_if.up_key    <= next_word.keys[1];
        in_if.down_key  <= next_word.keys[0];
        in_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    timer_word_t want;
    if (out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        $error("result word arrived with no prediction pending");
        errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("relay_on", want.relay_on, out_if.relay_on);
        check_field("period_seconds", want.period, out_if.period_seconds);
        check_field("remaining_seconds", want.remaining, out_if.remaining_seconds);
        check_field("chord_acted", want.acted, out_if.chord_acted);
        check_field("period_changed", want.changed, out_if.period_changed);
      end
    end
  end

  // Abort when no channel moves a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no handshake for %0d cycles", IdleLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_word(logic [1:0] act, logic [2:0] keys);
    key_word_t w;
    w.action = act;
    w.keys   = keys;
    pending_words.push_back(w);
  endtask

  // Press a chord and let go of all keys
  task automatic push_chord(logic [2:0] code);
    push_word(ActKey, code);
    push_word(ActKey, ChordNone);
  endtask

  // Build up a chord through a narrower one, hold it, release maybe in steps
  task automatic push_random_chord();
    logic [2:0] code;
    logic [2:0] part;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 25)      code = ChordDown;
    else if (r < 50) code = ChordUp;
    else if (r < 65) code = ChordBoth;
    else if (r < 70) code = ChordPower;
    else             code = 3'($urandom_range(5, 7));
    part = code & 3'($urandom_range(0, 7));
    if (part != ChordNone && $urandom_range(0, 1)) push_word(ActKey, part);
    repeat ($urandom_range(1, 3)) push_word(ActKey, code);
    if ($urandom_range(0, 3) == 0) push_word(ActKey, code & 3'($urandom_range(0, 7)));
    push_word(ActKey, ChordNone);
  endtask

  // Drain both channels, then leave room for the pipeline to settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_if.valid || expected_words.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_saved(logic [15:0] value);
    @(negedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.saved_seconds <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    saved_cfg = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] saved_corners[9];
    logic [15:0] pick;
    int          r;
    int          taken_base;

    saved_corners = '{16'd0, 16'd4, 16'd5, 16'd9, 16'd10,
                      16'd3590, 16'd3600, 16'd3601, 16'd65535};

    // Known values on every input from time zero
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.action         = ActKey;
    in_if.power_key      = 1'b0;
    in_if.up_key         = 1'b0;
    in_if.down_key       = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.saved_seconds = SavedReset;
    in_took = 1'b0;
    in_gap = 0;
    out_stall = 0;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    idle_cycles = 0;
    steady = 1'b0;
    words_taken = 0;
    live_words = 0;
    results_seen = 0;
    cfg_writes = 0;
    chords_acted = 0;
    shutdowns = 0;
    peak_remaining = 0;
    errors = 0;

    // Reset state of the predictor
    saved_cfg     = SavedReset;
    held_chord    = ChordNone;
    latched_chord = ChordNone;
    period_now    = DefaultPeriod;
    remaining_now = RemainReset;
    relay_now     = 1'b1;
    changed_now   = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: each chord kind, widening, power off and the ignored words
    push_word(ActTick, ChordNone);
    push_chord(ChordDown);
    push_chord(ChordUp);
    push_chord(ChordBoth);
    // widest chord wins and gets acted on again at full release
    push_word(ActKey, ChordDown);
    push_word(ActKey, ChordBoth);
    push_word(ActKey, ChordUp);
    push_word(ActKey, ChordNone);
    push_chord(ChordPowerDown);
    push_chord(ChordPowerUp);
    push_chord(ChordAll);
    push_word(ActUnused, ChordAll);
    push_chord(ChordPower);
    // relay is off: keys and ticks must change nothing
    push_word(ActKey, ChordUp);
    push_word(ActTick, ChordNone);
    push_word(ActKey, ChordNone);
    push_word(ActStart, ChordNone);

    // Hold the receiver off while the sender keeps offering words
    steady = 1'b1;
    hold_req++;
    repeat (10) push_random_chord();
    repeat (10) push_word(ActTick, ChordNone);
    wait_idle();
    steady = 1'b0;

    // Saved-period corners: fallback, limits of up and down, run-out by chord
    foreach (saved_corners[i]) begin
      wait_idle();
      write_saved(saved_corners[i]);
      push_word(ActStart, ChordNone);
      push_chord(ChordUp);
      push_chord(ChordUp);
      push_chord(ChordDown);
      push_chord(ChordDown);
      push_chord(ChordDown);
      push_word(ActTick, ChordNone);
      push_word(ActTick, ChordNone);
    end
    wait_idle();

    // Random: mostly proper chord sequences and tick runs, some noise
    steady = 1'b0;
    write_saved(16'd20);
    push_word(ActStart, ChordNone);
    taken_base = words_taken;
    while (words_taken - taken_base < RandomWords) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_random_chord();
      end else if (r < 70) begin
        repeat ($urandom_range(1, 8)) push_word(ActTick, 3'($urandom_range(0, 7)));
      end else if (r < 76) begin
        push_word(ActStart, 3'($urandom_range(0, 7)));
      end else if (r < 80) begin
        // new saved period, mostly short so ticks run out
        wait_idle();
        r = $urandom_range(0, 9);
        if (r < 5)      pick = 16'($urandom_range(5, 40));
        else if (r < 8) pick = 16'($urandom_range(5, 3600));
        else            pick = 16'($urandom_range(0, 65535));
        steady = ($urandom_range(0, 3) == 0);
        write_saved(pick);
        push_word(ActStart, ChordNone);
      end else begin
        push_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      end
      // throttle so the loop count tracks accepted words
      while (pending_words.size() > 8) @(posedge clk_i);
    end

    wait_idle();
    $display("Covered %0d input words (%0d acted on), %0d results, %0d saved-period writes",
             words_taken, live_words, results_seen, cfg_writes);
    $display("Chords executed: %0d, relay shutdowns: %0d, peak remaining: %0d s",
             chords_acted, shutdowns, peak_remaining);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ckst_pkg.sv
hdl/ckst_if.sv
hdl/ckst_front.sv
hdl/ckst_back.sv
hdl/chord_keyed_shutdown_timer.sv
tb/tb_chord_keyed_shutdown_timer.sv
